>>> src/csvt_pkg.sv
// Shared types, constants and helpers for the CSV line tokenizer.
// No dependencies; used by csvt_core and csv_line_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  // Column limit and register widths.
  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned CfgWidth    = 7;
  localparam int unsigned IdxWidth    = 7;
  localparam int unsigned ColWidth    = 6;

  localparam logic [IdxWidth-1:0] MaxColumnsIdx = IdxWidth'(MAX_COLUMNS);
  localparam logic [CfgWidth-1:0] ColumnCountReset = CfgWidth'(1);

  // Special bytes.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StMidQuote   = 3'd1,
    StEscComma   = 3'd2,
    StTooMany    = 3'd3,
    StBadEscape  = 3'd4,
    StTrailEsc   = 3'd5,
    StOpenQuote  = 3'd6,
    StCount      = 3'd7
  } status_e;

  // Per-line parser state.
  typedef struct packed {
    logic                in_quotes;
    logic                escape_pending;
    logic [IdxWidth-1:0] field_index;
    logic                field_has_char;
    logic                field_has_nonspace;
    logic                line_failed;
  } line_state_t;

  // One result beat.
  typedef struct packed {
    logic                char_valid;
    logic [7:0]          char_out;
    logic [ColWidth-1:0] column;
    logic                field_end;
    logic                line_end;
    status_e             status;
  } result_t;

  // White space: space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

>>> src/csvt_core.sv
// Combinational step of the tokenizer: one byte against the current line state.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvt_core (
  input  wire logic [7:0]                     char_i,
  input  wire logic                           last_i,
  input  wire logic [csvt_pkg::CfgWidth-1:0]  column_count_i,
  input  wire csvt_pkg::line_state_t          state_i,
  output csvt_pkg::line_state_t               state_o,
  output csvt_pkg::result_t                   result_o
);
  import csvt_pkg::*;

  logic [IdxWidth-1:0] limit;
  line_state_t         st;
  status_e             status;
  logic                emit;
  logic                fend;
  logic [IdxWidth-1:0] col;

  // Column counts above the maximum act as the maximum.
  assign limit = (column_count_i > CfgWidth'(MAX_COLUMNS)) ? MaxColumnsIdx
                                                            : IdxWidth'(column_count_i);

  always_comb begin
    st     = state_i;
    status = StOk;
    emit   = 1'b0;
    fend   = 1'b0;
    col    = '0;

    if (!state_i.line_failed) begin
      // Byte classification.
      if (char_i == ChQuote) begin
        if (st.escape_pending) begin
          emit              = 1'b1;
          st.escape_pending = 1'b0;
        end else if (st.in_quotes) begin
          st.in_quotes = 1'b0;
        end else if (!st.field_has_nonspace) begin
          st.in_quotes = 1'b1;
        end else begin
          status = StMidQuote;
        end
      end else if (char_i == ChComma) begin
        if (st.escape_pending) begin
          status = StEscComma;
        end else if (st.in_quotes) begin
          emit = 1'b1;
        end else if (st.field_index >= limit) begin
          status = StTooMany;
        end else begin
          fend                  = 1'b1;
          col                   = st.field_index;
          st.field_index        = st.field_index + IdxWidth'(1);
          st.field_has_char     = 1'b0;
          st.field_has_nonspace = 1'b0;
        end
      end else if (char_i == ChBackslash) begin
        if (st.escape_pending) begin
          emit              = 1'b1;
          st.escape_pending = 1'b0;
        end else begin
          st.escape_pending = 1'b1;
        end
      end else begin
        if (st.escape_pending) begin
          status = StBadEscape;
        end else begin
          emit = 1'b1;
        end
      end

      // Field character bookkeeping.
      if (emit) begin
        col               = st.field_index;
        st.field_has_char = 1'b1;
        if (!is_space(char_i)) begin
          st.field_has_nonspace = 1'b1;
        end
      end

      // Close the final field and check the field count.
      if (last_i && (status == StOk)) begin
        if (st.escape_pending) begin
          status = StTrailEsc;
        end else if (st.in_quotes) begin
          status = StOpenQuote;
        end else if (st.field_has_char || (char_i == ChComma)) begin
          if (st.field_index >= limit) begin
            status = StTooMany;
          end else begin
            fend           = 1'b1;
            col            = st.field_index;
            st.field_index = st.field_index + IdxWidth'(1);
          end
        end
        if ((status == StOk) && (st.field_index != limit)) begin
          status = StCount;
        end
      end

      if (status != StOk) begin
        emit           = 1'b0;
        fend           = 1'b0;
        col            = '0;
        st.line_failed = 1'b1;
      end
    end

    // A line end returns all line state to its reset value.
    state_o = last_i ? line_state_t'('0) : st;

    result_o.char_valid = emit;
    result_o.char_out   = emit ? char_i : 8'h00;
    result_o.column     = col[ColWidth-1:0];
    result_o.field_end  = fend;
    result_o.line_end   = last_i;
    result_o.status     = status;
  end

endmodule

`default_nettype wire

>>> src/csv_line_tokenizer.sv
// Top level of the CSV line tokenizer: input register, line state, result register.
// Depends on csvt_pkg and csvt_core.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte of a CSV line per
//   beat, with line_last_i set on the line's last byte. Output channel
//   (out_valid_o / out_ready_i) returns exactly one result beat per input beat,
//   in order: a field character with its column, a field end mark, a line end
//   mark and a status code.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes column_count;
//   it is always ready and should only be written while the block is idle.
//   An accepted byte waits in the input register; its result is loaded into the
//   result register once that register is empty or being drained. Throughput
//   is one byte per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its beat and the input
//   register holds one more byte; only then does in_ready_o drop.
//   Reset clears the valid flags of both registers and the line state, and sets column_count to 1.
`timescale 1ns / 1ps
`default_nettype none

module csv_line_tokenizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [csvt_pkg::CfgWidth-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [7:0]                    char_in_i,
  input  wire logic                          line_last_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          char_valid_o,
  output      logic [7:0]                    char_out_o,
  output      logic [csvt_pkg::ColWidth-1:0] column_o,
  output      logic                          field_end_o,
  output      logic                          line_end_o,
  output      logic [2:0]                    status_o
);
  import csvt_pkg::*;

  logic [CfgWidth-1:0] column_count_q;
  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                last_q;
  logic                out_valid_q;
  result_t             result_q;
  result_t             result_d;
  line_state_t         state_q;
  line_state_t         state_d;
  logic                advance;
  logic                load;

  // The result register can take a beat when empty or being drained.
  assign advance     = !out_valid_q || out_ready_i;
  assign load        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= ColumnCountReset;
    end else if (cfg_valid_i) begin
      column_count_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
      last_q <= line_last_i;
    end
  end

  csvt_core u_core (
    .char_i         (char_q),
    .last_i         (last_q),
    .column_count_i (column_count_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // The line state advances with each loaded beat; result valid updates whenever the result register can take a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = result_q.char_valid;
  assign char_out_o   = result_q.char_out;
  assign column_o     = result_q.column;
  assign field_end_o  = result_q.field_end;
  assign line_end_o   = result_q.line_end;
  assign status_o     = result_q.status;

  // An error beat never carries a character or a field end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.status != StOk)) |->
      (!result_q.char_valid && !result_q.field_end))
    else $error("error result carries field data");

  // The field index never passes the maximum column count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.field_index <= MaxColumnsIdx)
    else $error("field index beyond column limit");

  // After the last byte of a line is processed, the line state is clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_q) |=> (state_q == line_state_t'('0)))
    else $error("line state not cleared at line end");

  // A held input byte is kept while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(char_q) && $stable(last_q)))
    else $error("input register lost a byte during stall");

  // The line state only changes when a beat is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(state_q))
    else $error("line state changed without a beat");

endmodule

`default_nettype wire
